[rtl/acs_pkg.sv]
// Shared types and constants for the accelerometer sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  // Sample format and arithmetic constants
  localparam int unsigned SampleW       = 12;
  localparam int unsigned ResultW       = 13;
  localparam int unsigned NumAxes       = 3;
  localparam int unsigned AVERAGE_TAPS  = 4;
  localparam int unsigned SampleCenter  = 2048;
  localparam int unsigned ResetThresh   = 10;

  // Moving-average ring geometry
  localparam int unsigned RingIdxW = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int unsigned FillW    = $clog2(AVERAGE_TAPS + 1);
  localparam int unsigned SumW     = SampleW + $clog2(AVERAGE_TAPS);

  // Queue between front and back
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  // Stream widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegCalMode  = 3'd0;
  localparam logic [RegIdxW-1:0] RegOffsetX  = 3'd1;
  localparam logic [RegIdxW-1:0] RegOffsetY  = 3'd2;
  localparam logic [RegIdxW-1:0] RegOffsetZ  = 3'd3;
  localparam logic [RegIdxW-1:0] RegThresh   = 3'd4;

  typedef logic [SampleW-1:0] sample_t;

  // One queued item: unpacked samples, index 0 = x, 1 = y, 2 = z
  typedef sample_t [NumAxes-1:0] samples_t;

  typedef struct packed {
    logic                       cal_mode;
    logic signed [SampleW-1:0]  bias_x;
    logic signed [SampleW-1:0]  bias_y;
    logic signed [SampleW-1:0]  bias_z;
    logic        [SampleW-1:0]  threshold;
  } cfg_t;

  // Queue handshake between the front end and the back end
  typedef struct packed {
    logic     push;
    samples_t data;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    samples_t data;
  } q_rd_t;

endpackage

`default_nettype wire

[rtl/acs_cfg.sv]
// APB register file holding mode, per-axis offsets and deadband threshold.
`timescale 1ns / 1ps
`default_nettype none

module acs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [acs_pkg::ApbDataW-1:0]  pwdata,
  output logic [acs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output acs_pkg::cfg_t                 cfg_o
);
  import acs_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ApbAddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegCalMode: cfg_d.cal_mode  = pwdata[0];
        RegOffsetX: cfg_d.bias_x    = pwdata[SampleW-1:0];
        RegOffsetY: cfg_d.bias_y    = pwdata[SampleW-1:0];
        RegOffsetZ: cfg_d.bias_z    = pwdata[SampleW-1:0];
        RegThresh:  cfg_d.threshold = pwdata[SampleW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCalMode: prdata = {{(ApbDataW-1){1'b0}}, cfg_q.cal_mode};
      RegOffsetX: prdata = {{(ApbDataW-SampleW){1'b0}}, cfg_q.bias_x};
      RegOffsetY: prdata = {{(ApbDataW-SampleW){1'b0}}, cfg_q.bias_y};
      RegOffsetZ: prdata = {{(ApbDataW-SampleW){1'b0}}, cfg_q.bias_z};
      RegThresh:  prdata = {{(ApbDataW-SampleW){1'b0}}, cfg_q.threshold};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_mode  <= 1'b0;
      cfg_q.bias_x    <= '0;
      cfg_q.bias_y    <= '0;
      cfg_q.bias_z    <= '0;
      cfg_q.threshold <= SampleW'(ResetThresh);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/acs_front.sv]
// Front end: accept raw read beats, unpack the three 12-bit samples, push to queue.
`timescale 1ns / 1ps
`default_nettype none

module acs_front (
  input  logic [acs_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [0:0]                  s_axis_tuser,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic                        q_full_i,
  output acs_pkg::q_wr_t              q_wr_o
);
  import acs_pkg::*;

  logic [7:0] hi_byte [NumAxes];
  logic [7:0] lo_byte [NumAxes];

  assign s_axis_tready = ~q_full_i;

  always_comb begin
    q_wr_o.push = s_axis_tvalid & ~q_full_i;
    for (int a = 0; a < NumAxes; a++) begin
      hi_byte[a] = s_axis_tdata[16*a +: 8];
      lo_byte[a] = s_axis_tdata[16*a + 8 +: 8];
      // Drop the bytes of a failed read: the sample counts as zero
      if (s_axis_tuser[0]) begin
        q_wr_o.data[a] = '0;
      end else begin
        q_wr_o.data[a] = {hi_byte[a], lo_byte[a][7:4]};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/acs_queue.sv]
// Short FIFO of unpacked samples between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module acs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acs_pkg::q_wr_t  wr_i,
  output logic            full_o,
  output acs_pkg::q_rd_t  rd_o,
  input  logic            pop_i
);
  import acs_pkg::*;

  samples_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0]   count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o     = (count_q == QCountW'(QDepth));
  assign rd_o.valid = (count_q != '0);
  assign rd_o.data  = mem_q[rd_ptr_q];

  assign do_wr = wr_i.push & ~full_o;
  assign do_rd = pop_i & rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

endmodule

`default_nettype wire

[rtl/acs_back.sv]
// Back end: moving average, deadband stabiliser, centring and output register.
`timescale 1ns / 1ps
`default_nettype none

module acs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  acs_pkg::cfg_t                cfg_i,
  input  acs_pkg::q_rd_t               q_rd_i,
  output logic                         q_pop_o,
  output logic [acs_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);
  import acs_pkg::*;

  sample_t             ring_q   [NumAxes][AVERAGE_TAPS];
  logic [RingIdxW-1:0] pos_q    [NumAxes];
  logic [RingIdxW-1:0] pos_d    [NumAxes];
  logic [FillW-1:0]    fill_q   [NumAxes];
  logic [FillW-1:0]    fill_d   [NumAxes];
  sample_t             held_q   [NumAxes];
  sample_t             held_d   [NumAxes];

  logic [SumW-1:0]           sum      [NumAxes];
  sample_t                   avg_s    [NumAxes];
  sample_t                   stab_in  [NumAxes];
  logic signed [SampleW:0]   diff     [NumAxes];
  logic [SampleW:0]          mag      [NumAxes];
  logic signed [SampleW-1:0] offset   [NumAxes];
  logic signed [SampleW+1:0] res      [NumAxes];

  logic [OutDataW-1:0] data_q, data_d;
  logic                valid_q, valid_d;
  logic                take;

  assign take    = ~valid_q | m_axis_tready;
  assign q_pop_o = q_rd_i.valid & take;

  assign offset[0] = cfg_i.bias_x;
  assign offset[1] = cfg_i.bias_y;
  assign offset[2] = cfg_i.bias_z;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      // Sum the ring as it stands once the new sample is written in
      sum[a] = '0;
      for (int i = 0; i < AVERAGE_TAPS; i++) begin
        if (pos_q[a] == RingIdxW'(i)) begin
          sum[a] = sum[a] + SumW'(q_rd_i.data[a]);
        end else begin
          sum[a] = sum[a] + SumW'(ring_q[a][i]);
        end
      end
      // Pass the sample through until the ring has filled once
      if (fill_q[a] < FillW'(AVERAGE_TAPS)) begin
        avg_s[a] = q_rd_i.data[a];
      end else begin
        avg_s[a] = SampleW'(sum[a] / AVERAGE_TAPS);
      end
      stab_in[a] = cfg_i.cal_mode ? avg_s[a] : q_rd_i.data[a];

      diff[a] = $signed({1'b0, held_q[a]}) - $signed({1'b0, stab_in[a]});
      mag[a]  = diff[a][SampleW] ? unsigned'(-diff[a]) : unsigned'(diff[a]);
      held_d[a] = (mag[a] >= {1'b0, cfg_i.threshold}) ? stab_in[a] : held_q[a];

      res[a] = $signed({2'b00, held_d[a]}) - (SampleW + 2)'(SampleCenter);
      if (!cfg_i.cal_mode) begin
        res[a] = res[a] - (SampleW + 2)'(offset[a]);
        if (a < 2) begin
          res[a] = -res[a];
        end
      end

      pos_d[a]  = (pos_q[a] == RingIdxW'(AVERAGE_TAPS - 1)) ? '0 : pos_q[a] + 1'b1;
      fill_d[a] = (fill_q[a] < FillW'(AVERAGE_TAPS)) ? fill_q[a] + 1'b1 : fill_q[a];
    end
  end

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (q_pop_o) begin
      data_d  = {{(OutDataW - NumAxes*ResultW){1'b0}},
                 res[2][ResultW-1:0], res[1][ResultW-1:0], res[0][ResultW-1:0]};
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        pos_q[a]  <= '0;
        fill_q[a] <= '0;
        held_q[a] <= '0;
        for (int i = 0; i < AVERAGE_TAPS; i++) begin
          ring_q[a][i] <= '0;
        end
      end
    end else begin
      valid_q <= valid_d;
      if (q_pop_o) begin
        for (int a = 0; a < NumAxes; a++) begin
          held_q[a] <= held_d[a];
          // Leave the averaging state untouched in normal mode
          if (cfg_i.cal_mode) begin
            ring_q[a][pos_q[a]] <= q_rd_i.data[a];
            pos_q[a]            <= pos_d[a];
            fill_q[a]           <= fill_d[a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tdata  = data_q;
  assign m_axis_tvalid = valid_q;

endmodule

`default_nettype wire

[rtl/accel_sample_conditioner_top.sv]
// Top level of the accelerometer sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Contents
// s_axis    in         tvalid / tready             raw bytes of one 3-axis read
// m_axis    out        tvalid / tready             conditioned x, y, z counts
// apb       in/out     psel, penable, pready       mode, offsets, deadband
//
// One beat in and one beat out per cycle when both sides flow; an accepted beat
// goes into the queue, then into the output register that drives m_axis.
// The back end's averaging sum, deadband compare and centring are combinational.
// Reset clears the rings, fill counts, ring positions and held samples, sets
// the threshold to ten, and leaves the block ready at once.
// A two-entry queue parts the sides: s_axis keeps accepting while m_axis
// stalls until the queue fills, and the output register holds under stall.

module accel_sample_conditioner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // x_high_byte, x_low_byte, y_high_byte, y_low_byte, z_high_byte, z_low_byte
  input  logic [acs_pkg::InDataW-1:0]   s_axis_tdata,
  // read_failed
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // accel_x [12:0], accel_y [25:13], accel_z [38:26], zero pad [39]
  output logic [acs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [acs_pkg::ApbDataW-1:0]  pwdata,
  output logic [acs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import acs_pkg::*;

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Hold the configuration registers
  acs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept and unpack input beats
  acs_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .q_full_i      (q_full),
    .q_wr_o        (q_wr)
  );

  // Decouple the two sides
  acs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  // Filter, stabilise and centre, then register the result beat
  acs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_rd_i        (q_rd),
    .q_pop_o       (q_pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

`default_nettype wire

[tb/sv/accel_sample_conditioner_checker.sv]
// Stream checker: predicts conditioned accelerometer beats and compares them.
`timescale 1ns / 1ps

module accel_sample_conditioner_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // x_high_byte, x_low_byte, y_high_byte, y_low_byte, z_high_byte, z_low_byte
  input  logic [acs_pkg::InDataW-1:0]   s_tdata_i,
  // read_failed
  input  logic [0:0]                    s_tuser_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // accel_x, accel_y, accel_z, zero pad
  input  logic [acs_pkg::OutDataW-1:0]  m_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [acs_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [acs_pkg::ApbDataW-1:0]  pwdata_i,
  input  logic                          pready_i,
  output int                            outstanding_o,
  output int                            mismatches_o
);
  import acs_pkg::*;

  typedef struct packed {
    logic [ResultW-1:0] accel_z;
    logic [ResultW-1:0] accel_y;
    logic [ResultW-1:0] accel_x;
  } accel_t;

  accel_t pending_results [$];
  accel_t got_beat;
  accel_t want_beat;
  int     errors;

  logic                      cal_mode_q;
  logic signed [SampleW-1:0] offset_q [NumAxes];
  logic        [SampleW-1:0] threshold_q;

  sample_t                   ring_q    [NumAxes][AVERAGE_TAPS];
  logic [FillW-1:0]          fill_q    [NumAxes];
  logic [RingIdxW-1:0]       ring_pos_q[NumAxes];
  sample_t                   held_q    [NumAxes];

  // Advance the per-axis averaging and deadband state by one read.
  function automatic accel_t condition_read(input logic [InDataW-1:0] raw,
                                            input logic failed);
    accel_t              res;
    sample_t             s;
    logic [SumW-1:0]     sum;
    int                  diff;
    int                  r;
    logic [ResultW-1:0]  field [NumAxes];
    for (int a = 0; a < NumAxes; a++) begin
      s = failed ? '0 : {raw[16*a +: 8], raw[16*a+12 +: 4]};
      if (cal_mode_q) begin
        ring_q[a][ring_pos_q[a]] = s;
        ring_pos_q[a] = (ring_pos_q[a] == RingIdxW'(AVERAGE_TAPS - 1)) ? '0
                                                                      : ring_pos_q[a] + 1'b1;
        if (fill_q[a] < AVERAGE_TAPS) begin
          fill_q[a] = fill_q[a] + 1'b1;
        end else begin
          sum = '0;
          for (int i = 0; i < AVERAGE_TAPS; i++) sum = sum + ring_q[a][i];
          s = sample_t'(sum / AVERAGE_TAPS);
        end
      end
      diff = int'(held_q[a]) - int'(s);
      if (diff < 0) diff = -diff;
      if (diff >= int'(threshold_q)) held_q[a] = s;
      if (cal_mode_q) begin
        r = int'(held_q[a]) - int'(SampleCenter);
      end else begin
        r = int'(held_q[a]) - int'(SampleCenter) - int'(offset_q[a]);
        if (a < 2) r = -r;
      end
      field[a] = r[ResultW-1:0];
    end
    res.accel_x = field[0];
    res.accel_y = field[1];
    res.accel_z = field[2];
    return res;
  endfunction

  task automatic check_axis(input string name, input logic [ResultW-1:0] want,
                            input logic [ResultW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q  = 1'b0;
      threshold_q = SampleW'(ResetThresh);
      for (int a = 0; a < NumAxes; a++) begin
        offset_q[a]   = '0;
        fill_q[a]     = '0;
        ring_pos_q[a] = '0;
        held_q[a]     = '0;
        for (int i = 0; i < AVERAGE_TAPS; i++) ring_q[a][i] = '0;
      end
      pending_results.delete();
      errors        = 0;
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ApbAddrW-1:2])
          RegCalMode: cal_mode_q  = pwdata_i[0];
          RegOffsetX: offset_q[0] = pwdata_i[SampleW-1:0];
          RegOffsetY: offset_q[1] = pwdata_i[SampleW-1:0];
          RegOffsetZ: offset_q[2] = pwdata_i[SampleW-1:0];
          RegThresh:  threshold_q = pwdata_i[SampleW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        pending_results.push_back(condition_read(s_tdata_i, s_tuser_i[0]));
      if (m_tvalid_i && m_tready_i) begin
        got_beat = accel_t'(m_tdata_i[3*ResultW-1:0]);
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: x %0d y %0d z %0d",
                 $signed(got_beat.accel_x), $signed(got_beat.accel_y),
                 $signed(got_beat.accel_z));
          errors++;
        end else begin
          want_beat = pending_results.pop_front();
          check_axis("accel_x", want_beat.accel_x, got_beat.accel_x);
          check_axis("accel_y", want_beat.accel_y, got_beat.accel_y);
          check_axis("accel_z", want_beat.accel_z, got_beat.accel_z);
        end
      end
      outstanding_o <= pending_results.size();
      mismatches_o  <= errors;
    end
  end

endmodule

[tb/sv/accel_sample_conditioner_top_tb.sv]
// Testbench top: drives reads and register writes into the sample conditioner.
`timescale 1ns / 1ps

module accel_sample_conditioner_top_tb;
  import acs_pkg::*;

  // Register indexes past the last real register; writes there must be dropped
  localparam logic [RegIdxW-1:0] RegFirstUnused = RegThresh + 1'b1;
  localparam int                 StallLimit     = 2000;
  localparam int                 RandomReads    = 1750;
  localparam int                 SettleCycles   = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  int                   outstanding;
  int                   mismatches;
  int                   stall_cycles;
  logic                 no_idle;     // both sides run back to back while set
  int unsigned          cur_thresh;  // deadband in force, steers near-sample spans

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  accel_sample_conditioner_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  accel_sample_conditioner_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // Watchdog: count cycles in which no beat and no register access completes.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: draw a stall before each beat, then hold tready until it lands.
  initial begin : result_sink
    int unsigned gap;
    m_axis_tready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Lay out three samples as the six raw bytes, with noise in the unused nibbles.
  function automatic logic [InDataW-1:0] pack_read(input sample_t sx, input sample_t sy,
                                                   input sample_t sz);
    return {sz[3:0], 4'($urandom()), sz[11:4],
            sy[3:0], 4'($urandom()), sy[11:4],
            sx[3:0], 4'($urandom()), sx[11:4]};
  endfunction

  // Step a sample by a small amount, clamped to the 12-bit range.
  function automatic sample_t near_sample(input sample_t last, input int span);
    int v;
    v = int'(last) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // Offer one read beat after a random gap; return once it is accepted.
  task automatic send_read(input logic [InDataW-1:0] raw, input logic failed);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= failed;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Setup then access phase; psel stays up so writes can follow back to back.
  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop tvalid and wait until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned n_items;
    int unsigned kind;
    int          span;
    logic [ApbDataW-1:0] value;
    sample_t     last_s [NumAxes];

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    cur_thresh    = ResetThresh;
    foreach (last_s[a]) last_s[a] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: normal path, zero offsets, deadband of ten.
    send_read(pack_read(12'd0, 12'd0, 12'd0), 1'b0);
    send_read({InDataW{1'b1}}, 1'b0);
    send_read({InDataW{1'b1}}, 1'b1);          // failed read zeroes all axes
    send_read(pack_read(12'd9, 12'd9, 12'd9), 1'b0);     // just inside the deadband
    send_read(pack_read(12'd10, 12'd10, 12'd10), 1'b0);  // exactly on it
    send_read(pack_read(12'd2048, 12'd2048, 12'd2048), 1'b0);
    drain();

    // Extreme X and Y offsets, Z offset of -1, junk above bit 11 on X and Z, zero deadband, stray write past the map.
    cfg_write(RegOffsetX, 32'hABCD_E800);
    cfg_write(RegOffsetY, 32'h0000_07FF);
    cfg_write(RegOffsetZ, 32'h5A5A_AFFF);
    cfg_write(RegThresh, 32'h0001_0000);
    cfg_write(RegFirstUnused, $urandom());
    cfg_release();
    cur_thresh = 0;
    send_read(pack_read(12'd4095, 12'd0, 12'd2048), 1'b0);
    send_read(pack_read(12'd4095, 12'd0, 12'd2048), 1'b0);  // same sample taken again
    send_read(pack_read(12'd0, 12'd4095, 12'd1), 1'b0);
    drain();

    // Averaged path, deadband of one: pass-through while the ring fills, then mean.
    cfg_write(RegCalMode, 32'hFFFF_FFF1);
    cfg_write(RegThresh, 32'h0000_0001);
    cfg_release();
    cur_thresh = 1;
    send_read(pack_read(12'd100, 12'd200, 12'd300), 1'b0);
    send_read(pack_read(12'd104, 12'd207, 12'd301), 1'b0);
    send_read({InDataW{1'b1}}, 1'b1);
    send_read(pack_read(12'd4095, 12'd4095, 12'd4095), 1'b0);
    send_read(pack_read(12'd4095, 12'd4095, 12'd4095), 1'b0);
    send_read(pack_read(12'd1, 12'd2, 12'd3), 1'b0);
    drain();

    // Widest deadband: only a full-scale swing gets through.
    cfg_write(RegCalMode, 32'h0000_0000);
    cfg_write(RegThresh, 32'hFFFF_FFFF);
    cfg_release();
    cur_thresh = 4095;
    send_read(pack_read(12'd0, 12'd0, 12'd0), 1'b1);
    send_read(pack_read(12'd4095, 12'd4095, 12'd4095), 1'b0);
    send_read(pack_read(12'd0, 12'd4095, 12'd0), 1'b0);
    drain();

    // Random phases: fresh settings each time, then a burst of reads.
    sent = 0;
    while (sent < RandomReads) begin
      cfg_write(RegCalMode, $urandom());
      for (int a = 0; a < NumAxes; a++) begin
        case ($urandom_range(0, 3))
          0:       value = ($urandom() & ~32'hFFF) | 32'h800;
          1:       value = ($urandom() & ~32'hFFF) | 32'h7FF;
          default: value = $urandom();
        endcase
        cfg_write(RegOffsetX + RegIdxW'(a), value);
      end
      case ($urandom_range(0, 7))
        0:       cur_thresh = 0;
        1:       cur_thresh = 1;
        2:       cur_thresh = 4095;
        3:       cur_thresh = $urandom_range(0, 4095);
        default: cur_thresh = $urandom_range(2, 40);
      endcase
      cfg_write(RegThresh, ($urandom() & ~32'hFFF) | cur_thresh);
      if ($urandom_range(0, 2) == 0)
        cfg_write(RegFirstUnused + RegIdxW'($urandom_range(0, 2)), $urandom());
      cfg_release();

      no_idle = ($urandom_range(0, 3) == 0);
      span    = (cur_thresh < 4) ? 4 : ((cur_thresh > 256) ? 256 : int'(cur_thresh));
      n_items = $urandom_range(60, 160);
      for (int i = 0; i < n_items; i++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_read(InDataW'({$urandom(), $urandom()}), 1'b1);
        end else begin
          // Mostly walk around the last sample sent so the deadband decides often.
          for (int a = 0; a < NumAxes; a++)
            last_s[a] = (kind < 4) ? sample_t'($urandom()) : near_sample(last_s[a], span);
          send_read(pack_read(last_s[0], last_s[1], last_s[2]), 1'b0);
        end
      end
      sent += n_items;
      drain();
    end

    no_idle = 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
